// ----- sv/rsqc_pkg.sv -----
// ----------------------------------------------------------------------------
// rsqc_pkg
// Shared constants, types and helpers of the rotated sprite quad corner block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsqc_pkg;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int LIFE_W    = 32;
    localparam int SCALE_W   = 24;
    localparam int ANGLE_W   = 20;
    localparam int EXTENT_W  = 28;
    localparam int OPACITY_W = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF_HEIGHT = 2'd1;

    // Sine/cosine approximation constants (Q.16 unless noted)
    localparam logic [29:0] ANGLE_K       = 30'd683565276;  // 2/pi, Q.30
    localparam logic [16:0] CROSSING_Q16  = 17'd46105;      // 0.7035
    localparam logic [15:0] CURV_MAG_Q16  = 16'd53346;      // 0.814
    localparam logic [15:0] HALF_Q16      = 16'd32768;

    // Opacity of full life
    localparam logic [OPACITY_W-1:0] OPACITY_ONE = 17'd65536;

    // Sine/cosine width, and pipeline depth
    localparam int TRIG_W    = 18;
    localparam int SC_STAGES = 4;
    localparam int STAGES    = 7;

    // Offset width after rounding to 16 fractional bits
    localparam int OFS_W = 40;

    // Per-stage load enables of the sine/cosine unit
    typedef logic [SC_STAGES-1:0] sc_en_t;

    // Clamp a corner sum to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [OFS_W:0] v
    );
        logic signed [COORD_W-1:0] res;
        if (v[OFS_W:COORD_W-1] == '0 || v[OFS_W:COORD_W-1] == '1)
            res = v[COORD_W-1:0];
        else if (v[OFS_W])
            res = {1'b1, {(COORD_W-1){1'b0}}};
        else
            res = {1'b0, {(COORD_W-1){1'b1}}};
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/rsqc_ifs.sv -----
// ----------------------------------------------------------------------------
// rsqc interfaces
// Particle input, corner result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsqc_particle_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rsqc_pkg::COORD_W-1:0]  center_x;
    logic signed [rsqc_pkg::COORD_W-1:0]  center_y;
    logic signed [rsqc_pkg::LIFE_W-1:0]   remaining_life;
    logic        [rsqc_pkg::SCALE_W-1:0]  sprite_scale;
    logic signed [rsqc_pkg::ANGLE_W-1:0]  rotation_angle;

    modport source (output valid, center_x, center_y, remaining_life,
                    sprite_scale, rotation_angle, input ready);
    modport sink   (input valid, center_x, center_y, remaining_life,
                    sprite_scale, rotation_angle, output ready);
endinterface

interface rsqc_corners_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rsqc_pkg::COORD_W-1:0]   corner0_x;
    logic signed [rsqc_pkg::COORD_W-1:0]   corner0_y;
    logic signed [rsqc_pkg::COORD_W-1:0]   corner1_x;
    logic signed [rsqc_pkg::COORD_W-1:0]   corner1_y;
    logic signed [rsqc_pkg::COORD_W-1:0]   corner2_x;
    logic signed [rsqc_pkg::COORD_W-1:0]   corner2_y;
    logic signed [rsqc_pkg::COORD_W-1:0]   corner3_x;
    logic signed [rsqc_pkg::COORD_W-1:0]   corner3_y;
    logic        [rsqc_pkg::OPACITY_W-1:0] opacity;

    modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y,
                    corner2_x, corner2_y, corner3_x, corner3_y, opacity,
                    input ready);
    modport sink   (input valid, corner0_x, corner0_y, corner1_x, corner1_y,
                    corner2_x, corner2_y, corner3_x, corner3_y, opacity,
                    output ready);
endinterface

interface rsqc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rsqc_pkg::CFG_IDX_W-1:0]     index;
    logic [rsqc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/rsqc_sincos.sv -----
// ----------------------------------------------------------------------------
// rsqc_sincos
// Four-stage parabolic sine/cosine of a Q3.16 angle, Q.16 results.
// ----------------------------------------------------------------------------
`default_nettype none

module rsqc_sincos (
    input  wire logic                                 clk,
    input  wire rsqc_pkg::sc_en_t                     en,
    input  wire logic signed [rsqc_pkg::ANGLE_W-1:0]  angle,
    output logic signed [rsqc_pkg::TRIG_W-1:0]        sin_q,
    output logic signed [rsqc_pkg::TRIG_W-1:0]        cos_q
);

    // Stage A: scale by 2/pi, split quadrant and fraction
    logic signed [rsqc_pkg::ANGLE_W+30:0] raw;
    logic [1:0]  quad_a_reg;
    logic [15:0] frac_a_reg;

    assign raw = angle * $signed({1'b0, rsqc_pkg::ANGLE_K});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            quad_a_reg <= raw[47:46];
            frac_a_reg <= raw[45:30];
        end
    end

    // Stage B: center the fraction and square it
    logic signed [15:0] r_b;
    logic signed [31:0] rr_b;
    logic [1:0]         quad_b_reg;
    logic signed [15:0] r_b_reg;
    logic [14:0]        q_b_reg;

    assign r_b  = $signed({~frac_a_reg[15], frac_a_reg[14:0]});
    assign rr_b = r_b * r_b;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            quad_b_reg <= quad_a_reg;
            r_b_reg    <= r_b;
            q_b_reg    <= rr_b[30:16];
        end
    end

    // Stage C: curvature product
    logic [1:0]         quad_c_reg;
    logic signed [15:0] r_c_reg;
    logic [30:0]        qm_c_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            quad_c_reg <= quad_b_reg;
            r_c_reg    <= r_b_reg;
            qm_c_reg   <= 31'(q_b_reg) * 31'(rsqc_pkg::CURV_MAG_Q16);
        end
    end

    // Stage D: parabola, quadrant swap and signs
    logic [30:0]                        qm_rnd;
    logic signed [16:0]                 shared_d;
    logic signed [rsqc_pkg::TRIG_W-1:0] s_raw;
    logic signed [rsqc_pkg::TRIG_W-1:0] c_raw;
    logic signed [rsqc_pkg::TRIG_W-1:0] s_sw;
    logic signed [rsqc_pkg::TRIG_W-1:0] c_sw;
    logic signed [rsqc_pkg::TRIG_W-1:0] sin_next;
    logic signed [rsqc_pkg::TRIG_W-1:0] cos_next;
    logic signed [rsqc_pkg::TRIG_W-1:0] sin_reg;
    logic signed [rsqc_pkg::TRIG_W-1:0] cos_reg;

    always_comb
    begin
        qm_rnd   = qm_c_reg + 31'(rsqc_pkg::HALF_Q16);
        shared_d = $signed(rsqc_pkg::CROSSING_Q16) - $signed({3'b000, qm_rnd[29:16]});
        s_raw    = 18'(shared_d) + 18'(r_c_reg);
        c_raw    = 18'(shared_d) - 18'(r_c_reg);
        s_sw     = quad_c_reg[0] ? c_raw : s_raw;
        c_sw     = quad_c_reg[0] ? s_raw : c_raw;
        sin_next = quad_c_reg[1] ? -s_sw : s_sw;
        cos_next = (quad_c_reg[1] ^ quad_c_reg[0]) ? -c_sw : c_sw;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

`default_nettype wire

// ----- sv/rotated_sprite_quad_corners.sv -----
// ----------------------------------------------------------------------------
// rotated_sprite_quad_corners
// Four corners of a rotated, scaled sprite quad plus clamped opacity.
// ----------------------------------------------------------------------------
// The block takes one particle per clock unless stalled and returns its four
// quad corners and opacity through a seven-stage pipeline: extent scaling and
// the 2/pi angle product, rounding and the fraction square, the curvature
// product, the parabola with quadrant fix-up, the four offset products, offset
// sums with rounding, and the saturating corner adds into the output register.
// Each stage holds only while the stage after it is full and blocked, so the
// input keeps taking particles while a finished result waits. Configuration
// writes (half_width at index 0, half_height at index 1, low 28 bits kept) are
// always ready; keeping them to idle periods is left to the user.
`default_nettype none

module rotated_sprite_quad_corners (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rsqc_particle_if.sink particle,
    rsqc_corners_if.source corners,
    rsqc_cfg_if.sink      cfg
);

    localparam int N  = rsqc_pkg::STAGES;
    localparam int CW = rsqc_pkg::COORD_W;
    localparam int EW = rsqc_pkg::EXTENT_W;
    localparam int TW = rsqc_pkg::TRIG_W;
    localparam int OW = rsqc_pkg::OFS_W;
    localparam int PW = EW + rsqc_pkg::SCALE_W;   // extent product
    localparam int SW = PW - 16;                  // rounded scaled extent
    localparam int MW = SW + 1 + TW;              // offset product
    localparam int AW = MW + 1;                   // offset sum

    // Configuration registers
    logic [EW-1:0] half_width_reg;
    logic [EW-1:0] half_height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= '0;
            half_height_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == rsqc_pkg::CFG_IDX_HALF_WIDTH)
                half_width_reg <= cfg.data[EW-1:0];
            if (cfg.index == rsqc_pkg::CFG_IDX_HALF_HEIGHT)
                half_height_reg <= cfg.data[EW-1:0];
        end
    end

    // Stage enables: a stage loads when it is empty or its successor moves
    logic [N-1:0] en;
    logic [N-1:0] v_reg;

    always_comb
    begin
        en[N-1] = !v_reg[N-1] || corners.ready;
        for (int k = N - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign particle.ready = en[0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= particle.valid;
            for (int k = 1; k < N; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // Sine/cosine unit runs alongside stages 1 to 4
    logic signed [TW-1:0] sin_q;
    logic signed [TW-1:0] cos_q;

    rsqc_sincos u_sincos (
        .clk   (clk),
        .en    (en[rsqc_pkg::SC_STAGES-1:0]),
        .angle (particle.rotation_angle),
        .sin_q (sin_q),
        .cos_q (cos_q)
    );

    // Stage 1: extent products, opacity clamp
    logic [PW-1:0]                   pw1_reg;
    logic [PW-1:0]                   ph1_reg;
    logic signed [CW-1:0]            cx1_reg;
    logic signed [CW-1:0]            cy1_reg;
    logic [rsqc_pkg::OPACITY_W-1:0]  op1_reg;
    logic [rsqc_pkg::OPACITY_W-1:0]  op_next;

    always_comb
    begin
        if (particle.remaining_life[rsqc_pkg::LIFE_W-1])
            op_next = '0;
        else if (particle.remaining_life > $signed({15'd0, rsqc_pkg::OPACITY_ONE}))
            op_next = rsqc_pkg::OPACITY_ONE;
        else
            op_next = particle.remaining_life[rsqc_pkg::OPACITY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pw1_reg <= half_width_reg * particle.sprite_scale;
            ph1_reg <= half_height_reg * particle.sprite_scale;
            cx1_reg <= particle.center_x;
            cy1_reg <= particle.center_y;
            op1_reg <= op_next;
        end
    end

    // Stage 2: round scaled extents to 16 fractional bits
    logic [PW-1:0]                  pw_rnd;
    logic [PW-1:0]                  ph_rnd;
    logic [SW-1:0]                  sw2_reg, sw3_reg, sw4_reg;
    logic [SW-1:0]                  sh2_reg, sh3_reg, sh4_reg;
    logic signed [CW-1:0]           cx2_reg, cx3_reg, cx4_reg, cx5_reg, cx6_reg;
    logic signed [CW-1:0]           cy2_reg, cy3_reg, cy4_reg, cy5_reg, cy6_reg;
    logic [rsqc_pkg::OPACITY_W-1:0] op2_reg, op3_reg, op4_reg, op5_reg, op6_reg;

    assign pw_rnd = pw1_reg + PW'(rsqc_pkg::HALF_Q16);
    assign ph_rnd = ph1_reg + PW'(rsqc_pkg::HALF_Q16);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sw2_reg <= pw_rnd[PW-1:16];
            sh2_reg <= ph_rnd[PW-1:16];
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
            op2_reg <= op1_reg;
        end
    end

    // Stages 3 and 4: hold extents and center while the sine/cosine settles
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            sw3_reg <= sw2_reg;
            sh3_reg <= sh2_reg;
            cx3_reg <= cx2_reg;
            cy3_reg <= cy2_reg;
            op3_reg <= op2_reg;
        end
        if (en[3])
        begin
            sw4_reg <= sw3_reg;
            sh4_reg <= sh3_reg;
            cx4_reg <= cx3_reg;
            cy4_reg <= cy3_reg;
            op4_reg <= op3_reg;
        end
    end

    // Stage 5: four offset products
    logic signed [SW:0]   sw_s;
    logic signed [SW:0]   sh_s;
    logic signed [MW-1:0] swc5_reg, shs5_reg, sws5_reg, shc5_reg;

    assign sw_s = $signed({1'b0, sw4_reg});
    assign sh_s = $signed({1'b0, sh4_reg});

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            swc5_reg <= sw_s * cos_q;
            shs5_reg <= sh_s * sin_q;
            sws5_reg <= sw_s * sin_q;
            shc5_reg <= sh_s * cos_q;
            cx5_reg  <= cx4_reg;
            cy5_reg  <= cy4_reg;
            op5_reg  <= op4_reg;
        end
    end

    // Stage 6: offset sums, round half up to 16 fractional bits
    logic signed [AW-1:0] sx0, sy0, sx1, sy1;
    logic signed [OW-1:0] dx0_reg, dy0_reg, dx1_reg, dy1_reg;

    always_comb
    begin
        sx0 = AW'(shs5_reg) - AW'(swc5_reg) + AW'(rsqc_pkg::HALF_Q16);
        sy0 = -(AW'(sws5_reg) + AW'(shc5_reg)) + AW'(rsqc_pkg::HALF_Q16);
        sx1 = AW'(swc5_reg) + AW'(shs5_reg) + AW'(rsqc_pkg::HALF_Q16);
        sy1 = AW'(sws5_reg) - AW'(shc5_reg) + AW'(rsqc_pkg::HALF_Q16);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            dx0_reg <= sx0[OW+15:16];
            dy0_reg <= sy0[OW+15:16];
            dx1_reg <= sx1[OW+15:16];
            dy1_reg <= sy1[OW+15:16];
            cx6_reg <= cx5_reg;
            cy6_reg <= cy5_reg;
            op6_reg <= op5_reg;
        end
    end

    // Stage 7: saturating corner adds into the output register
    logic signed [OW:0] cx_e, cy_e;
    logic signed [CW-1:0] c0x_reg, c0y_reg, c1x_reg, c1y_reg;
    logic signed [CW-1:0] c2x_reg, c2y_reg, c3x_reg, c3y_reg;
    logic [rsqc_pkg::OPACITY_W-1:0] op7_reg;

    assign cx_e = (OW+1)'(cx6_reg);
    assign cy_e = (OW+1)'(cy6_reg);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            c0x_reg <= rsqc_pkg::sat_coord(cx_e + (OW+1)'(dx0_reg));
            c0y_reg <= rsqc_pkg::sat_coord(cy_e + (OW+1)'(dy0_reg));
            c1x_reg <= rsqc_pkg::sat_coord(cx_e + (OW+1)'(dx1_reg));
            c1y_reg <= rsqc_pkg::sat_coord(cy_e + (OW+1)'(dy1_reg));
            c2x_reg <= rsqc_pkg::sat_coord(cx_e - (OW+1)'(dx0_reg));
            c2y_reg <= rsqc_pkg::sat_coord(cy_e - (OW+1)'(dy0_reg));
            c3x_reg <= rsqc_pkg::sat_coord(cx_e - (OW+1)'(dx1_reg));
            c3y_reg <= rsqc_pkg::sat_coord(cy_e - (OW+1)'(dy1_reg));
            op7_reg <= op6_reg;
        end
    end

    // Drive the result channel
    assign corners.valid     = v_reg[N-1];
    assign corners.corner0_x = c0x_reg;
    assign corners.corner0_y = c0y_reg;
    assign corners.corner1_x = c1x_reg;
    assign corners.corner1_y = c1y_reg;
    assign corners.corner2_x = c2x_reg;
    assign corners.corner2_y = c2y_reg;
    assign corners.corner3_x = c3x_reg;
    assign corners.corner3_y = c3y_reg;
    assign corners.opacity   = op7_reg;

endmodule

`default_nettype wire

// ----- sv/rsqc_checker.sv -----
// ----------------------------------------------------------------------------
// rsqc_checker
// Port-level checks of the sprite quad corner block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsqc_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 in_ready,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic signed [rsqc_pkg::COORD_W-1:0]  corner0_x,
    input wire logic signed [rsqc_pkg::COORD_W-1:0]  corner3_y,
    input wire logic [rsqc_pkg::OPACITY_W-1:0]       opacity
);

    // Result beat holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before handshake");

    // Stalled result payload stays put, checked on corner0_x, corner3_y and opacity
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(corner0_x) && $stable(corner3_y)
                                    && $stable(opacity))
        else $error("stalled result payload changed");

    // A free output drains the whole pipe, so the input must be open
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output is ready");

    // Opacity never exceeds one
    a_opacity_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> opacity <= rsqc_pkg::OPACITY_ONE)
        else $error("opacity above one");

endmodule

bind rotated_sprite_quad_corners rsqc_checker u_rsqc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (particle.ready),
    .out_valid (corners.valid),
    .out_ready (corners.ready),
    .corner0_x (corners.corner0_x),
    .corner3_y (corners.corner3_y),
    .opacity   (corners.opacity)
);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotated sprite quad corner block.
// ----------------------------------------------------------------------------
// Particles go in on the particle channel and quad beats come back on the
// corners channel. Every accepted particle is run through a fixed-point model
// of the parabolic sine/cosine, extent scaling, offset rounding and corner
// saturation. The modeled quad is queued, and each returned beat is checked
// field by field against the oldest queued quad. Extent registers are
// rewritten only between phases, once the pipeline has drained.

module testbench;

    // Run limits
    localparam int    SETTLE_CYCLES = rsqc_pkg::STAGES + 4;
    localparam time   TIMEOUT_NS    = 10_000_000;

    // Unmapped register indexes, writes there must be dropped
    localparam logic [rsqc_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 2'd2;
    localparam logic [rsqc_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 2'd3;

    // Sine/cosine approximation constants, Q.30 gain and Q.16 terms
    localparam longint TWO_OVER_PI_Q30 = 683565276;
    localparam longint PARABOLA_PEAK   = 46105;
    localparam longint PARABOLA_CURVE  = 53346;
    localparam longint HALF_LSB        = 32768;
    localparam longint OPACITY_FULL    = 65536;
    localparam longint COORD_MAX       = 64'sd2147483647;
    localparam longint COORD_MIN       = -64'sd2147483648;

    typedef struct {
        logic signed [rsqc_pkg::COORD_W-1:0] center_x;
        logic signed [rsqc_pkg::COORD_W-1:0] center_y;
        logic signed [rsqc_pkg::LIFE_W-1:0]  remaining_life;
        logic        [rsqc_pkg::SCALE_W-1:0] sprite_scale;
        logic signed [rsqc_pkg::ANGLE_W-1:0] rotation_angle;
    } sprite_in_t;

    typedef struct {
        logic signed [rsqc_pkg::COORD_W-1:0]   x0;
        logic signed [rsqc_pkg::COORD_W-1:0]   y0;
        logic signed [rsqc_pkg::COORD_W-1:0]   x1;
        logic signed [rsqc_pkg::COORD_W-1:0]   y1;
        logic signed [rsqc_pkg::COORD_W-1:0]   x2;
        logic signed [rsqc_pkg::COORD_W-1:0]   y2;
        logic signed [rsqc_pkg::COORD_W-1:0]   x3;
        logic signed [rsqc_pkg::COORD_W-1:0]   y3;
        logic        [rsqc_pkg::OPACITY_W-1:0] opacity;
    } quad_corners_t;

    logic clk = 1'b0;
    logic rst_n;

    rsqc_particle_if particle_bus ();
    rsqc_corners_if  corners_bus ();
    rsqc_cfg_if      cfg_bus ();

    rotated_sprite_quad_corners dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .particle (particle_bus),
        .corners  (corners_bus),
        .cfg      (cfg_bus)
    );

    // Shadow copy of the extent registers
    logic [rsqc_pkg::EXTENT_W-1:0] shadow_half_w;
    logic [rsqc_pkg::EXTENT_W-1:0] shadow_half_h;

    quad_corners_t pending_quads[$];
    quad_corners_t oldest_quad;

    int  particles_sent  = 0;
    int  quads_checked   = 0;
    int  reg_writes      = 0;
    int  mismatch_count  = 0;

    // Idle control for both sides
    bit  src_gaps        = 1'b0;
    bit  snk_stalls      = 1'b0;
    int  stall_left      = 0;
    int  holdoff_req     = 0;
    int  holdoff_left    = 0;

    // Clock, 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Round a Q.32 product sum to Q.16: add one half, then floor
    function automatic longint round_q16(input longint v);
        return (v + HALF_LSB) >>> 16;
    endfunction

    function automatic logic signed [rsqc_pkg::COORD_W-1:0] clamp_coord(input longint v);
        longint c;
        c = v;
        if (c > COORD_MAX)
            c = COORD_MAX;
        if (c < COORD_MIN)
            c = COORD_MIN;
        return c[rsqc_pkg::COORD_W-1:0];
    endfunction

    function automatic quad_corners_t rotate_quad(input sprite_in_t p);
        longint        phase;
        logic [63:0]   biased;
        logic [1:0]    quadrant;
        logic [1:0]    next_quadrant;
        longint        r;
        longint        sq;
        longint        shared;
        longint        sn;
        longint        cs;
        longint        tmp;
        longint        sw;
        longint        sh;
        longint        dx0;
        longint        dy0;
        longint        dx1;
        longint        dy1;
        longint        cx;
        longint        cy;
        longint        life;
        quad_corners_t q;

        // Split angle*2/pi into quadrant and 16-bit fraction
        phase         = longint'(p.rotation_angle) * TWO_OVER_PI_Q30;
        biased        = phase + (64'd1 << 50);
        quadrant      = biased[47:46];
        next_quadrant = quadrant + 2'd1;
        r             = longint'({48'd0, biased[45:30]}) - HALF_LSB;

        // Parabola shared by sine and cosine
        sq     = (r * r) >>> 16;
        shared = PARABOLA_PEAK - ((sq * PARABOLA_CURVE + HALF_LSB) >>> 16);
        sn     = shared + r;
        cs     = shared - r;
        if (quadrant[0])
        begin
            tmp = sn;
            sn  = cs;
            cs  = tmp;
        end
        if (quadrant[1])
            sn = -sn;
        if (next_quadrant[1])
            cs = -cs;

        // Scaled half extents, rounded to 16 fractional bits
        sw = longint'((64'(shadow_half_w) * 64'(p.sprite_scale) + 64'd32768) >> 16);
        sh = longint'((64'(shadow_half_h) * 64'(p.sprite_scale) + 64'd32768) >> 16);

        dx0 = round_q16(sh * sn - sw * cs);
        dy0 = round_q16(-(sw * sn + sh * cs));
        dx1 = round_q16(sw * cs + sh * sn);
        dy1 = round_q16(sw * sn - sh * cs);

        cx = longint'(p.center_x);
        cy = longint'(p.center_y);
        q.x0 = clamp_coord(cx + dx0);
        q.y0 = clamp_coord(cy + dy0);
        q.x1 = clamp_coord(cx + dx1);
        q.y1 = clamp_coord(cy + dy1);
        q.x2 = clamp_coord(cx - dx0);
        q.y2 = clamp_coord(cy - dy0);
        q.x3 = clamp_coord(cx - dx1);
        q.y3 = clamp_coord(cy - dy1);

        life = longint'(p.remaining_life);
        if (life < 0)
            life = 0;
        if (life > OPACITY_FULL)
            life = OPACITY_FULL;
        q.opacity = life[rsqc_pkg::OPACITY_W-1:0];
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic sprite_in_t make_sprite(
        input logic [31:0] cx,
        input logic [31:0] cy,
        input logic [31:0] life,
        input logic [23:0] scl,
        input logic [19:0] ang
    );
        sprite_in_t p;
        p.center_x       = cx;
        p.center_y       = cy;
        p.remaining_life = life;
        p.sprite_scale   = scl;
        p.rotation_angle = ang;
        return p;
    endfunction

    // Mostly full-range coordinates, some near either rail
    function automatic logic [31:0] skewed_coord();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'h7FFF_0000 | $urandom_range(0, 65535);
            1:       v = 32'h8000_0000 | $urandom_range(0, 65535);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic sprite_in_t random_sprite();
        sprite_in_t  p;
        logic [31:0] life;
        logic [23:0] scl;
        case ($urandom_range(0, 3))
            0:       life = $urandom;
            3:       life = 32'(OPACITY_FULL + $urandom_range(0, 2) - 1);
            default: life = $urandom_range(0, 163840) - 32768;
        endcase
        if ($urandom_range(0, 7) == 0)
            scl = 24'($urandom);
        else
            scl = 24'($urandom_range(0, 131072));
        p = make_sprite(skewed_coord(), skewed_coord(), life, scl, 20'($urandom));
        return p;
    endfunction

    function automatic logic [31:0] random_extent();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 16);
            default: v = $urandom_range(0, 64 << 16);
        endcase
        return v;
    endfunction

    // Report one mismatch on a line of its own and count it
    task automatic flag_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want)
            flag_error($sformatf("beat %0d %s: got %0d, expected %0d",
                                 quads_checked, name, got, want));
    endtask

    // Offer one particle, hold it until the beat is taken
    task automatic send_particle(input sprite_in_t p);
        int gap;
        gap = src_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            particle_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        particle_bus.valid          = 1'b1;
        particle_bus.center_x       = p.center_x;
        particle_bus.center_y       = p.center_y;
        particle_bus.remaining_life = p.remaining_life;
        particle_bus.sprite_scale   = p.sprite_scale;
        particle_bus.rotation_angle = p.rotation_angle;
        do
            @(posedge clk);
        while (!particle_bus.ready);
        pending_quads.push_back(rotate_quad(p));
        particles_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every queued quad, then let the pipeline settle
    task automatic drain_pipeline();
        particle_bus.valid = 1'b0;
        while (pending_quads.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [rsqc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == rsqc_pkg::CFG_IDX_HALF_WIDTH)
            shadow_half_w = value[rsqc_pkg::EXTENT_W-1:0];
        else if (idx == rsqc_pkg::CFG_IDX_HALF_HEIGHT)
            shadow_half_h = value[rsqc_pkg::EXTENT_W-1:0];
        reg_writes++;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic set_extents(input logic [31:0] hw, input logic [31:0] hh);
        write_reg(rsqc_pkg::CFG_IDX_HALF_WIDTH, hw);
        write_reg(rsqc_pkg::CFG_IDX_HALF_HEIGHT, hh);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extents are zero out of reset: every corner sits on the center
    task automatic test_zero_extent();
        src_gaps   = 1'b1;
        snk_stalls = 1'b1;
        send_particle(make_sprite(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                  24'hFF_FFFF, 20'h7_FFFF));
        send_particle(make_sprite(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 24'd0, 20'h8_0000));
        send_particle(make_sprite($urandom, $urandom, 32'(OPACITY_FULL), 24'($urandom),
                                  20'($urandom)));
        drain_pipeline();
    endtask

    // High data bits are masked, unmapped indexes leave the extents alone
    task automatic test_register_map();
        write_reg(rsqc_pkg::CFG_IDX_HALF_WIDTH, 32'hFFFF_FFFF);
        write_reg(rsqc_pkg::CFG_IDX_HALF_HEIGHT, 32'hF123_4567);
        write_reg(IDX_UNMAPPED_LO, $urandom);
        write_reg(IDX_UNMAPPED_HI, $urandom);
        send_particle(make_sprite(32'd0, 32'd0, 32'd32768, 24'hFF_FFFF, 20'h1_2345));
        send_particle(make_sprite($urandom, $urandom, 32'h7FFF_FFFF, 24'd65536, 20'h8_1234));
        drain_pipeline();
    endtask

    // Angle extremes, quadrant edges, life clamps, corner saturation
    task automatic test_field_extremes();
        set_extents(8 << 16, 4 << 16);
        send_particle(make_sprite(32'd0, 32'd0, 32'h8000_0000, 24'd65536, 20'd0));
        send_particle(make_sprite(32'd0, 32'd0, 32'hFFFF_FFFF, 24'd65536, -20'sd1));
        send_particle(make_sprite(32'd0, 32'd0, 32'd0, 24'd65536, 20'd1));
        send_particle(make_sprite(32'd0, 32'd0, 32'd1, 24'd65536, 20'h7_FFFF));
        send_particle(make_sprite(32'd0, 32'd0, 32'd65535, 24'd65536, 20'h8_0000));
        send_particle(make_sprite(32'd0, 32'd0, 32'd65536, 24'd65536, 20'd102944));
        send_particle(make_sprite(32'd0, 32'd0, 32'd65537, 24'd65536, 20'd102945));
        send_particle(make_sprite(32'd0, 32'd0, 32'h7FFF_FFFF, 24'd65536, -20'sd102944));
        send_particle(make_sprite(32'h7FFF_FFF0, 32'h8000_0010, 32'd40000, 24'hFF_FFFF,
                                  20'd205887));
        send_particle(make_sprite(32'h8000_0010, 32'h7FFF_FFF0, 32'd40000, 24'hFF_FFFF,
                                  -20'sd308831));
        send_particle(make_sprite(32'h1234_5678, 32'hEDCB_A988, 32'd1000, 24'd0, 20'h3_0000));
        send_particle(make_sprite(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd70000, 24'd65536,
                                  20'd51472));
        drain_pipeline();
    endtask

    // Full rate on both sides
    task automatic test_back_to_back();
        set_extents(16 << 16, 9 << 16);
        src_gaps   = 1'b0;
        snk_stalls = 1'b0;
        repeat (100) send_particle(random_sprite());
        drain_pipeline();
    endtask

    // Hold the output off long enough that the pipeline fills and stalls input
    task automatic test_input_stall();
        set_extents(random_extent(), random_extent());
        src_gaps   = 1'b0;
        snk_stalls = 1'b0;
        @(posedge clk);
        holdoff_req = 200;
        @(negedge clk);
        repeat (40) send_particle(random_sprite());
        snk_stalls = 1'b1;
        repeat (40) send_particle(random_sprite());
        drain_pipeline();
    endtask

    task automatic run_phase(input logic [31:0] hw, input logic [31:0] hh,
                             input bit gaps, input bit stalls);
        set_extents(hw, hh);
        src_gaps   = gaps;
        snk_stalls = stalls;
        repeat (110) send_particle(random_sprite());
        drain_pipeline();
    endtask

    // Several extent settings, extremes included, under mixed idling
    task automatic test_random_settings();
        run_phase(32'd0, 32'd0, 1'b1, 1'b1);
        run_phase(32'h0FFF_FFFF, 32'h0FFF_FFFF, 1'b1, 1'b0);
        run_phase(random_extent(), random_extent(), 1'b0, 1'b1);
        run_phase(32'h0FFF_FFFF, 32'd0, 1'b1, 1'b1);
        run_phase(32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        run_phase($urandom, $urandom, 1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Drive ready: long hold-off first, then per-beat random stalls
    initial
    begin
        corners_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (holdoff_req != 0)
            begin
                holdoff_left = holdoff_req;
                holdoff_req  = 0;
            end
            if (holdoff_left > 0)
            begin
                corners_bus.ready = 1'b0;
                holdoff_left--;
            end
            else if (stall_left > 0)
            begin
                corners_bus.ready = 1'b0;
                stall_left--;
            end
            else
                corners_bus.ready = 1'b1;
        end
    end

    // Check each quad beat against the oldest queued quad
    always @(posedge clk)
    begin
        if (rst_n && corners_bus.valid && corners_bus.ready)
        begin
            stall_left = snk_stalls ? $urandom_range(0, 14) : 0;
            if (pending_quads.size() == 0)
                flag_error("quad beat with no particle outstanding");
            else
            begin
                oldest_quad = pending_quads.pop_front();
                compare_field("corner0_x", corners_bus.corner0_x, oldest_quad.x0);
                compare_field("corner0_y", corners_bus.corner0_y, oldest_quad.y0);
                compare_field("corner1_x", corners_bus.corner1_x, oldest_quad.x1);
                compare_field("corner1_y", corners_bus.corner1_y, oldest_quad.y1);
                compare_field("corner2_x", corners_bus.corner2_x, oldest_quad.x2);
                compare_field("corner2_y", corners_bus.corner2_y, oldest_quad.y2);
                compare_field("corner3_x", corners_bus.corner3_x, oldest_quad.x3);
                compare_field("corner3_y", corners_bus.corner3_y, oldest_quad.y3);
                compare_field("opacity", corners_bus.opacity, oldest_quad.opacity);
                quads_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n                       = 1'b0;
        particle_bus.valid          = 1'b0;
        particle_bus.center_x       = '0;
        particle_bus.center_y       = '0;
        particle_bus.remaining_life = '0;
        particle_bus.sprite_scale   = '0;
        particle_bus.rotation_angle = '0;
        cfg_bus.valid               = 1'b0;
        cfg_bus.index               = rsqc_pkg::CFG_IDX_HALF_WIDTH;
        cfg_bus.data                = '0;
        shadow_half_w               = '0;
        shadow_half_h               = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_zero_extent();
        test_register_map();
        test_field_extremes();
        test_back_to_back();
        test_input_stall();
        test_random_settings();

        $display("Run covered %0d particles and %0d quad beats over %0d register writes.",
                 particles_sent, quads_checked, reg_writes);
        $display("Mismatches found: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop if the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d quads outstanding", pending_quads.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
